>>> sv/smd_pkg.sv
// Shared constants and a helper function for the SHA-256 message digest block.
`timescale 1ns / 1ps
`default_nettype none
package smd_pkg;

    typedef logic [31:0] word_t;

    localparam int WordCount = 8;
    localparam int SchedDepth = 16;
    localparam logic [7:0] PadByte = 8'h80;

    localparam word_t [0:7] InitHash = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t [0:63] RoundK = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> sv/sha256_message_digest.sv
// Top level of the SHA-256 message digest block with its round sequencer.
//
// Message bytes enter one per item and are taken while the block buffer
// fills. The 64th byte of a block starts a compression that runs one round
// per cycle through a single shared round unit and a 16-word schedule shift
// line, then folds the result into the hash, with input stalled throughout.
// An item marked last starts padding, which feeds 0x80, zeros and the bit
// length through the same byte path at one byte per cycle outside the
// compressions, with one or two compressions, and then the eight digest words
// leave through an output register, one per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_valid,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] msg_reg, msg_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        wrap_reg, wrap_next;
    logic        final_reg, final_next;
    logic        oval_reg, oval_next;

    smd_pkg::word_t h_reg [smd_pkg::WordCount];
    smd_pkg::word_t h_next [smd_pkg::WordCount];
    smd_pkg::word_t v_reg [smd_pkg::WordCount];
    smd_pkg::word_t v_next [smd_pkg::WordCount];
    smd_pkg::word_t w_reg [smd_pkg::SchedDepth];
    smd_pkg::word_t w_next [smd_pkg::SchedDepth];
    logic [23:0] acc_reg, acc_next;
    smd_pkg::word_t dw_reg, dw_next;
    logic [2:0]  idx_reg, idx_next;
    logic        lw_reg, lw_next;

    logic        accept;
    logic        ins_en;
    logic [7:0]  ins_byte;
    logic [5:0]  fill_inc;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic        out_load;
    smd_pkg::word_t s0, s1, big_s0, big_s1, ch, maj, t1, t2, w_new;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign fill_inc = fill_reg + 6'd1;
    assign bit_len  = {msg_reg, 3'b000};
    assign len_byte = 8'(bit_len >> {3'd7 - fill_reg[2:0], 3'b000});
    assign out_load = (state_reg == ST_OUT) && (!oval_reg || !out_stall);

    always_comb
    begin
        s0 = smd_pkg::ror(w_reg[1], 7) ^ smd_pkg::ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = smd_pkg::ror(w_reg[14], 17) ^ smd_pkg::ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        big_s1 = smd_pkg::ror(v_reg[4], 6) ^ smd_pkg::ror(v_reg[4], 11)
               ^ smd_pkg::ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big_s1 + ch + smd_pkg::RoundK[rnd_reg] + w_reg[0];
        big_s0 = smd_pkg::ror(v_reg[0], 2) ^ smd_pkg::ror(v_reg[0], 13)
               ^ smd_pkg::ror(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big_s0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        msg_next   = msg_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        wrap_next  = wrap_reg;
        final_next = final_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        ins_en     = 1'b0;
        ins_byte   = msg_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ins_en = byte_valid;
                    if (byte_valid)
                    begin
                        msg_next = msg_reg + 61'd1;
                    end
                    if (last)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                ins_en = 1'b1;
                if (first_reg)
                begin
                    ins_byte   = smd_pkg::PadByte;
                    first_next = 1'b0;
                    wrap_next  = (fill_inc > 6'd56);
                end
                else if (fill_reg >= 6'd56 && !wrap_reg)
                begin
                    ins_byte = len_byte;
                    if (fill_inc == 6'd0)
                    begin
                        final_next = 1'b1;
                    end
                end
                else
                begin
                    ins_byte = 8'h00;
                end
            end
            ST_COMP:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < smd_pkg::SchedDepth - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[smd_pkg::SchedDepth - 1] = w_new;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < smd_pkg::WordCount; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (final_reg)
                begin
                    state_next = ST_OUT;
                    cnt_next   = 3'd0;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        for (int i = 0; i < smd_pkg::WordCount; i++)
                        begin
                            h_next[i] = smd_pkg::InitHash[i];
                        end
                        msg_next   = '0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_en)
        begin
            acc_next  = {acc_reg[15:0], ins_byte};
            fill_next = fill_inc;
            if (fill_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < smd_pkg::SchedDepth - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[smd_pkg::SchedDepth - 1] = {acc_reg, ins_byte};
            end
            if (fill_inc == 6'd0)
            begin
                state_next = ST_COMP;
                rnd_next   = 6'd0;
                wrap_next  = 1'b0;
                v_next     = h_reg;
            end
        end
    end

    always_comb
    begin
        oval_next = oval_reg && out_stall;
        dw_next   = dw_reg;
        idx_next  = idx_reg;
        lw_next   = lw_reg;
        if (out_load)
        begin
            oval_next = 1'b1;
            dw_next   = h_reg[cnt_reg];
            idx_next  = cnt_reg;
            lw_next   = (cnt_reg == 3'd7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            msg_reg   <= '0;
            rnd_reg   <= '0;
            cnt_reg   <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            wrap_reg  <= 1'b0;
            final_reg <= 1'b0;
            oval_reg  <= 1'b0;
            for (int i = 0; i < smd_pkg::WordCount; i++)
            begin
                h_reg[i] <= smd_pkg::InitHash[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            msg_reg   <= msg_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            wrap_reg  <= wrap_next;
            final_reg <= final_next;
            oval_reg  <= oval_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        w_reg   <= w_next;
        acc_reg <= acc_next;
        dw_reg  <= dw_next;
        idx_reg <= idx_next;
        lw_reg  <= lw_next;
    end

    assign out_valid   = oval_reg;
    assign digest_word = dw_reg;
    assign word_index  = idx_reg;
    assign last_word   = lw_reg;

    // A compression always starts on a full block at its first round.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMP) ##1 (state_reg == ST_COMP) |-> (rnd_reg == 6'd0 && fill_reg == 6'd0))
        else $error("Compression started on a partial block.");

    // The last digest word always carries index seven.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("Last word flag disagrees with the word index.");

    // Digest words leave only after the final compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT) |-> $past(state_reg == ST_ADD && final_reg))
        else $error("Digest output began before the final block.");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the SHA-256 message digest block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        byte_valid;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    smd_pkg::word_t hash_model [8];
    logic [7:0]     block_model [64];
    int unsigned    fill_model;
    logic [60:0]    length_model;
    digest_item_t   digest_queue [$];
    bit             failed;
    bit             quiet;

    sha256_message_digest u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .msg_byte(msg_byte), .byte_valid(byte_valid), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic smd_pkg::word_t rotr(smd_pkg::word_t v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress_block();
        smd_pkg::word_t sched [64];
        smd_pkg::word_t a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_model[4*i], block_model[4*i+1],
                        block_model[4*i+2], block_model[4*i+3]};
        for (int i = 16; i < 64; i++)
            sched[i] = sched[i-16] + sched[i-7]
                + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
                + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
        a = hash_model[0]; b = hash_model[1]; c = hash_model[2]; d = hash_model[3];
        e = hash_model[4]; f = hash_model[5]; g = hash_model[6]; h = hash_model[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                + smd_pkg::RoundK[i] + sched[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_model[0] += a; hash_model[1] += b; hash_model[2] += c; hash_model[3] += d;
        hash_model[4] += e; hash_model[5] += f; hash_model[6] += g; hash_model[7] += h;
    endfunction

    function automatic void restart_digest();
        for (int i = 0; i < 8; i++)
            hash_model[i] = smd_pkg::InitHash[i];
        fill_model = 0;
        length_model = '0;
    endfunction

    function automatic void predict_digest(logic [7:0] b, logic bv, logic lst);
        logic [63:0] bits;
        digest_item_t r;
        if (bv)
        begin
            block_model[fill_model] = b;
            fill_model = (fill_model + 1) % 64;
            length_model = length_model + 61'd1;
            if (fill_model == 0)
                compress_block();
        end
        if (!lst)
            return;
        bits = {length_model, 3'b000};
        block_model[fill_model] = smd_pkg::PadByte;
        for (int i = fill_model + 1; i < 64; i++)
            block_model[i] = 8'h00;
        if (fill_model + 9 > 64)
        begin
            compress_block();
            for (int i = 0; i < 64; i++)
                block_model[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            block_model[63-i] = bits[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            r.digest_word = hash_model[i];
            r.word_index = 3'(i);
            r.last_word = (i == 7);
            digest_queue = {digest_queue, r};
        end
        restart_digest();
    endfunction

    task automatic send_item(logic [7:0] b, logic bv, logic lst);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        msg_byte <= b;
        byte_valid <= bv;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(b, bv, lst);
    endtask

    task automatic send_message(int len, bit last_has_byte);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), last_has_byte, 1'b1);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
    endtask

    task automatic test_block_edges();
        send_message(63, 1'b0);
    endtask

    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 32)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
                sent += 1;
            end
            else
            begin
                int len;
                len = $urandom_range(0, 12);
                send_message(len, 1'($urandom));
                sent += len + 1;
            end
        end
        quiet = 1'b1;
        send_message(3, 1'b0);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && !quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                failed = 1'b1;
            end
            else
            begin
                digest_item_t e;
                e = digest_queue.pop_front();
                if (digest_word !== e.digest_word)
                begin
                    $error("digest_word expected %h actual %h", e.digest_word, digest_word);
                    failed = 1'b1;
                end
                if (word_index !== e.word_index)
                begin
                    $error("word_index expected %0d actual %0d", e.word_index, word_index);
                    failed = 1'b1;
                end
                if (last_word !== e.last_word)
                begin
                    $error("last_word expected %0d actual %0d", e.last_word, last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        failed = 1'b0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        msg_byte = 8'h00;
        byte_valid = 1'b0;
        last = 1'b0;
        out_stall = 1'b0;
        restart_digest();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_block_edges();
        test_random_messages();
        in_valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
sv/smd_pkg.sv
sv/sha256_message_digest.sv
tb/sv/testbench.sv
